/* rtl/ipl_pkg.sv */
// Shared types, constants and helpers for the instrument program lookup block.
package ipl_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int SCAN_LIMIT  = (MAX_ENTRIES < 128) ? MAX_ENTRIES : 128;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(SCAN_LIMIT + 1);
  localparam int IDX_W       = 7;
  localparam int FIELD_W     = 7;
  localparam int COUNT_W     = 8;
  localparam int IDENT_W     = 1 + 3 * FIELD_W;

  typedef logic [IDENT_W-1:0] ident_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    RULE_EXACT   = 2'd0,
    RULE_BANK0   = 2'd1,
    RULE_PROG0   = 2'd2,
    RULE_DEFAULT = 2'd3
  } rule_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    rule_t            rule;
    logic             empty;
  } result_t;

  function automatic ident_t pack_identity(input logic drum,
                                           input logic [FIELD_W-1:0] bhi,
                                           input logic [FIELD_W-1:0] blo,
                                           input logic [FIELD_W-1:0] prog);
    return {drum, bhi, blo, prog};
  endfunction

endpackage

/* rtl/ipl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module ipl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ipl_scan.sv */
// Sequencer that writes table entries and scans the table for a lookup.
module ipl_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [ipl_pkg::IDX_W-1:0]       entry_index,
  input  logic                            drum_flag,
  input  logic [ipl_pkg::FIELD_W-1:0]     bank_high,
  input  logic [ipl_pkg::FIELD_W-1:0]     bank_low,
  input  logic [ipl_pkg::FIELD_W-1:0]     program_req,
  input  logic [ipl_pkg::COUNT_W-1:0]     entry_count,
  output logic                            ram_we,
  output logic [ipl_pkg::ADDR_W-1:0]      ram_waddr,
  output ipl_pkg::ident_t                 ram_wdata,
  output logic [ipl_pkg::ADDR_W-1:0]      ram_raddr,
  input  ipl_pkg::ident_t                 ram_rdata,
  output ipl_pkg::result_t                result
);
  import ipl_pkg::*;

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    last;
  logic [CNT_W-1:0]    rd_idx;
  logic                vld;
  ident_t              key;
  logic [2:0]          hit, hit_next;
  logic [IDX_W-1:0]    found [3];
  logic [IDX_W-1:0]    found_next [3];
  ident_t              want [3];
  logic                accept;
  logic                take_lookup;
  logic [COUNT_W-1:0]  limit;
  ident_t              in_ident;
  result_t             result_next;

  assign accept      = start && !busy;
  assign take_lookup = accept && (action == ACT_LOOKUP);
  assign in_ident    = pack_identity(drum_flag, bank_high, bank_low, program_req);
  assign limit       = (entry_count > COUNT_W'(SCAN_LIMIT)) ? COUNT_W'(SCAN_LIMIT)
                                                            : entry_count;

  // The three candidate patterns: exact, bank 0/0, bank 0/0 with program 0.
  assign want[0] = key;
  assign want[1] = {key[IDENT_W-1], {(2 * FIELD_W){1'b0}}, key[FIELD_W-1:0]};
  assign want[2] = {key[IDENT_W-1], {(IDENT_W - 1){1'b0}}};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_lookup && (limit != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    ram_we    = accept && (action == ACT_WRITE) && (32'(entry_index) < MAX_ENTRIES);
    ram_waddr = ADDR_W'(entry_index);
    ram_wdata = in_ident;
    ram_raddr = ADDR_W'(cnt);
  end

  // First-match tracking for all three rules at once.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      hit_next[r]   = hit[r];
      found_next[r] = found[r];
      if (vld && !hit[r] && (ram_rdata == want[r])) begin
        hit_next[r]   = 1'b1;
        found_next[r] = IDX_W'(rd_idx);
      end
    end
  end

  always_comb begin
    result_next       = '0;
    result_next.rule  = RULE_DEFAULT;
    if (take_lookup && (limit == '0)) begin
      result_next.valid = 1'b1;
      result_next.empty = 1'b1;
    end else if (state == ST_FLUSH) begin
      result_next.valid = 1'b1;
      priority if (hit_next[0]) begin
        result_next.index = found_next[0];
        result_next.rule  = RULE_EXACT;
      end else if (hit_next[1]) begin
        result_next.index = found_next[1];
        result_next.rule  = RULE_BANK0;
      end else if (hit_next[2]) begin
        result_next.index = found_next[2];
        result_next.rule  = RULE_PROG0;
      end else begin
        result_next.index = '0;
        result_next.rule  = RULE_DEFAULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      vld    <= 1'b0;
      hit    <= '0;
      result <= '0;
    end else begin
      state  <= state_next;
      vld    <= (state == ST_SCAN);
      result <= result_next;
      if (take_lookup) begin
        hit <= '0;
      end else begin
        hit <= hit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    for (int r = 0; r < 3; r++) begin
      found[r] <= found_next[r];
    end
    if (take_lookup) begin
      key  <= in_ident;
      cnt  <= '0;
      last <= CNT_W'(limit - COUNT_W'(1));
    end else if (state == ST_SCAN) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ram_we) else $error("table written during a scan");

  a_flush_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |=> result.valid) else $error("scan ended without a result");

  a_empty_default: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.empty) |-> (result.rule == RULE_DEFAULT && result.index == '0))
    else $error("empty-table result is not the default entry");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= last)) else $error("scan ran past the last entry");

endmodule

/* rtl/instrument_program_lookup_core.sv */
// Top level of the instrument program lookup block: configuration, table and scanner.
//
// The block keeps a table of up to 128 instrument identities (drum flag, bank MSB,
// bank LSB, program) in one synchronous RAM. A transaction with action 0 writes one
// entry, so write transactions may follow each other on every clock while busy is
// low. A transaction with action 1 looks an identity up: the scanner reads
// the entries below entry_count one per cycle through the RAM read port, tracking the
// first exact match, the first bank 0/0 match and the first bank 0/0 program 0 match
// at once. A lookup keeps busy high through the scan and flush states; its result is
// registered in the flush state and appears as busy falls, when the next transaction
// can already be accepted. A lookup lasts longer the more entries it scans in the
// table; its length is set by the single RAM read port. A lookup on an empty table
// answers on the next cycle with table_empty set, entry 0 and the default rule. Each
// result is presented for exactly one cycle with result_valid high and must be taken
// then, since the receiver cannot hold it off. The entry_count register is written
// through its own channel, which is always ready, and should be changed only while
// the block is idle; values above 128 are treated as 128. Entries must be written
// before a lookup reaches them, as the table has no reset. There is no clearing pass.
module instrument_program_lookup_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action,
  input  logic [ipl_pkg::IDX_W-1:0]    entry_index,
  input  logic                         drum_flag,
  input  logic [ipl_pkg::FIELD_W-1:0]  bank_high,
  input  logic [ipl_pkg::FIELD_W-1:0]  bank_low,
  input  logic [ipl_pkg::FIELD_W-1:0]  program_req,
  output logic                         result_valid,
  output logic [ipl_pkg::IDX_W-1:0]    instrument_index,
  output logic [1:0]                   match_rule,
  output logic                         table_empty,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ipl_pkg::COUNT_W-1:0]  cfg_data
);
  import ipl_pkg::*;

  logic [COUNT_W-1:0] entry_count;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  ident_t             ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  ident_t             ram_rdata;
  result_t            result;

  // The configuration channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  ipl_ram #(
    .WIDTH (IDENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ipl_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .entry_index (entry_index),
    .drum_flag   (drum_flag),
    .bank_high   (bank_high),
    .bank_low    (bank_low),
    .program_req (program_req),
    .entry_count (entry_count),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .result      (result)
  );

  // Results leave straight from the scanner's output register.
  assign result_valid     = result.valid;
  assign instrument_index = result.index;
  assign match_rule       = result.rule;
  assign table_empty      = result.empty;

endmodule
